// ----- design/assert_macros.svh -----
// Assertion macros used by the design file nibble_wildcard_pattern_scan.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define NWPS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define NWPS_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define NWPS_ASSERT(label, prop, msg)

`define NWPS_ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ----- design/nwps_pkg.sv -----
package nwps_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned NIBBLE_W = 4;
	localparam int unsigned PAT_BYTES = 16;
	localparam int unsigned WILD_W = 32;
	localparam int unsigned LEN_W = 5;
	localparam int unsigned COUNT_W = 31;
	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned APB_ADDR_W = 5;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
	localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		REG_PAT_LO = 2'd0,
		REG_PAT_HI = 2'd1,
		REG_WILD   = 2'd2,
		REG_LEN    = 2'd3
	} reg_idx_t;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
		logic [WILD_W-1:0]                wild;
	} pat_cfg_t;

endpackage

// ----- design/nwps_if.sv -----
interface nwps_in_if;
	logic                         valid;
	logic                         ready;
	logic [nwps_pkg::BYTE_W-1:0]  data_byte;
	logic                         end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface nwps_out_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [nwps_pkg::COUNT_W-1:0]  match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink (input valid, input found, input match_offset, output ready);
endinterface

// ----- design/nwps_match.sv -----
module nwps_match #(
	parameter int unsigned MAX_PATTERN_BYTES = 16
) (
	input  nwps_pkg::byte_t [MAX_PATTERN_BYTES-1:0] window,
	input  nwps_pkg::pat_cfg_t                      cfg,
	input  logic [nwps_pkg::LEN_W-1:0]              len,
	output logic                                    hit
);
	import nwps_pkg::*;

	logic [MAX_PATTERN_BYTES-1:0] pos_ok;

	always_comb begin
		logic [LEN_W-1:0]    pi;
		byte_t               pb;
		byte_t               wb;
		logic                wild_hi;
		logic                wild_lo;
		logic                hi_ok;
		logic                lo_ok;
		for (int p = 0; p < MAX_PATTERN_BYTES; p++) begin
			pi = len - LEN_W'(1) - LEN_W'(p);
			pb = cfg.pattern[pi[3:0]];
			wb = window[p];
			wild_hi = cfg.wild[{pi[3:0], 1'b0}];
			wild_lo = cfg.wild[{pi[3:0], 1'b1}];
			hi_ok = wild_hi || ((wb[7:4] & NIBBLE_MASK) == (pb[7:4] & NIBBLE_MASK));
			lo_ok = wild_lo || ((wb[3:0] & NIBBLE_MASK) == (pb[3:0] & NIBBLE_MASK));
			pos_ok[p] = (LEN_W'(p) >= len) || (hi_ok && lo_ok);
		end
	end

	assign hit = &pos_ok;

endmodule

// ----- design/nibble_wildcard_pattern_scan.sv -----
// Scans each buffer of a byte stream for the first place where a pattern of 1
// to 16 bytes occurs, each pattern nibble either fixed or a wildcard. One byte
// is taken per cycle: the byte lands in an input register, the whole window is
// compared with the pattern in that cycle, and the result word is held in an
// output register, so a new byte can enter every cycle while the result side
// keeps up. A buffer gives exactly one result word: found with the start offset
// of the first match, or found low when its last byte arrives without a match.
// Bytes after a match are dropped until the end of the buffer. The user must
// write APB registers only while the stream is idle; this is not enforced.
module nibble_wildcard_pattern_scan #(
	parameter int unsigned MAX_PATTERN_BYTES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	nwps_in_if.sink                           in_ch,
	nwps_out_if.source                        out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [nwps_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [nwps_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [nwps_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import nwps_pkg::*;

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN_BYTES);

	logic [63:0]            pat_lo_q;
	logic [63:0]            pat_hi_q;
	logic [WILD_W-1:0]      wild_q;
	logic [LEN_W-1:0]       len_q;
	reg_idx_t               reg_idx;
	logic                   cfg_wr;
	pat_cfg_t               cfg;
	logic [LEN_W-1:0]       len_eff;

	logic                   s1_valid_q;
	byte_t                  data_s1;
	logic                   last_s1;

	byte_t [MAX_PATTERN_BYTES-1:0] window_q;
	byte_t [MAX_PATTERN_BYTES-1:0] win_cur;
	logic [COUNT_W-1:0]     seen_q;
	logic                   reported_q;

	logic                   out_valid_q;
	logic                   found_q;
	logic [COUNT_W-1:0]     offset_q;

	logic                   adv;
	logic                   s1_fire;
	logic                   in_fire;
	logic                   window_hit;
	logic                   enough;
	logic                   hit;
	logic                   res_load;

	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			wild_q <= '0;
			len_q <= LEN_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PAT_LO: pat_lo_q <= pwdata;
				REG_PAT_HI: pat_hi_q <= pwdata;
				REG_WILD:   wild_q <= pwdata[WILD_W-1:0];
				REG_LEN:    len_q <= pwdata[LEN_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PAT_LO: prdata = pat_lo_q;
			REG_PAT_HI: prdata = pat_hi_q;
			REG_WILD:   prdata = {{(APB_DATA_W-WILD_W){1'b0}}, wild_q};
			REG_LEN:    prdata = {{(APB_DATA_W-LEN_W){1'b0}}, len_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.pattern = {pat_hi_q, pat_lo_q};
	assign cfg.wild = wild_q;

	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_q > MaxLen) begin
			len_eff = MaxLen;
		end else begin
			len_eff = len_q;
		end
	end

	assign adv = !out_valid_q || out_ch.ready;
	assign s1_fire = s1_valid_q && adv;
	assign in_ch.ready = !s1_valid_q || adv;
	assign in_fire = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.end_of_buffer;
		end
	end

	always_comb begin
		win_cur[0] = data_s1;
		for (int p = 1; p < MAX_PATTERN_BYTES; p++) begin
			win_cur[p] = window_q[p-1];
		end
	end

	nwps_match #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_match (
		.window(win_cur),
		.cfg(cfg),
		.len(len_eff),
		.hit(window_hit)
	);

	assign enough = seen_q >= (COUNT_W'(len_eff) - COUNT_W'(1));
	assign hit = !reported_q && window_hit && enough;
	assign res_load = s1_fire && !reported_q && (hit || last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q <= '0;
			reported_q <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				window_q <= '0;
				seen_q <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				window_q <= win_cur;
				if (seen_q != COUNT_MAX) begin
					seen_q <= seen_q + COUNT_W'(1);
				end
				reported_q <= hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q <= hit;
			offset_q <= hit ? (seen_q - (COUNT_W'(len_eff) - COUNT_W'(1))) : '0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.found = found_q;
	assign out_ch.match_offset = offset_q;

`include "assert_macros.svh"

	`NWPS_ASSERT(a_miss_zero_offset, out_valid_q && !found_q |-> offset_q == '0, "Miss word carries a nonzero offset.")
	`NWPS_ASSERT(a_last_clears, s1_fire && last_s1 |=> seen_q == '0 && !reported_q, "End of buffer did not clear the scan state.")
	`NWPS_ASSERT_NEVER(a_no_second_word, res_load && reported_q, "A second result word was loaded for one buffer.")
	`NWPS_ASSERT(a_empty_stage_ready, !s1_valid_q |-> in_ch.ready, "Input stalled with an empty input stage.")
	`NWPS_ASSERT(a_held_word, out_valid_q && !out_ch.ready |=> out_valid_q && $stable(offset_q), "Result word changed while stalled.")

endmodule
